### rtl/arce_pkg.sv
`default_nettype none

package arce_pkg;

  localparam int unsigned DefaultMaxRounds = 14;
  localparam int unsigned WordsPerRound    = 4;

  typedef enum logic [1:0] {
    OpLoadSub  = 2'd0,
    OpLoadKey  = 2'd1,
    OpEncrypt  = 2'd2
  } opcode_e;

  // Element 15 holds block byte 0, so block byte i sits at element ~i.
  typedef logic [15:0][7:0] block_t;

  function automatic logic [7:0] gf_double(logic [7:0] a);
    logic [7:0] r;
    r = {a[6:0], 1'b0};
    if (a[7]) begin
      r = r ^ 8'h1b;
    end
    return r;
  endfunction

  // Column mix of one column, row 0 in the top byte.
  function automatic logic [31:0] mix_column(logic [31:0] col);
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] d0, d1, d2, d3;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    d0 = gf_double(a0);
    d1 = gf_double(a1);
    d2 = gf_double(a2);
    d3 = gf_double(a3);
    return {d0 ^ d1 ^ a1 ^ a2 ^ a3,
            a0 ^ d1 ^ d2 ^ a2 ^ a3,
            a0 ^ a1 ^ d2 ^ d3 ^ a3,
            d0 ^ a0 ^ a1 ^ a2 ^ d3};
  endfunction

endpackage

`default_nettype wire

### rtl/aes_round_capture_engine.sv
// Load transactions are accepted back to back.
// An encrypt transaction first adds the round-0 key to the loaded block and hands off that
// result; each further round then makes 16 lookups through the single table port, the four
// round-key reads and the result hand-off. The next transaction is accepted once the last
// round result is handed off, and a stalled output holds both the rounds and that acceptance.
// Reset clears the control logic and sets round_count to 10; the memories are not cleared.
`default_nettype none

module aes_round_capture_engine
  import arce_pkg::*;
#(
  parameter int unsigned MaxRounds = DefaultMaxRounds
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_entry_i,
  input  logic [5:0]  key_word_index_i,
  input  logic [31:0] key_word_i,
  input  logic [63:0] plaintext_hi_i,
  input  logic [63:0] plaintext_lo_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  round_number_o,
  output logic [63:0] state_hi_o,
  output logic [63:0] state_lo_o,
  output logic        last_o
);

  localparam int unsigned KeyWords = WordsPerRound * (MaxRounds + 1);
  localparam int unsigned KeyAw    = $clog2(KeyWords);

  typedef enum logic [4:0] {
    StIdle     = 5'b00001,
    StSub      = 5'b00010,
    StKey      = 5'b00100,
    StKeyDrain = 5'b01000,
    StEmit     = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] round_count_q;
  logic [3:0] nr_q, nr_d;
  logic [3:0] rnd_q, rnd_d;
  logic [3:0] idx_q, idx_d;
  logic [1:0] col_q, col_d;
  logic       sub_vld_q;
  logic [3:0] sub_idx_q;
  logic       key_vld_q;
  logic [1:0] key_col_q;
  block_t     s_q, s_d;
  block_t     t_q, t_d;
  logic       out_valid_q, out_valid_d;
  logic [3:0] out_round_q;
  block_t     out_state_q;
  logic       out_last_q;
  logic       out_load;

  logic       accept;
  logic       sub_we;
  logic       key_we;
  logic [3:0] src_idx;
  logic [7:0] sub_raddr;
  logic [7:0] sub_rdata;
  logic [KeyAw-1:0] key_raddr;
  logic [31:0] key_rdata;
  logic [3:0] nr_clamped;
  block_t     key_src;
  logic [31:0] col_in;
  logic [31:0] col_out;
  logic        do_mix;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign sub_we     = accept && (opcode_i == OpLoadSub);
  assign key_we     = accept && (opcode_i == OpLoadKey)
                      && ({1'b0, key_word_index_i} < 7'(KeyWords));

  // Source byte for the combined substitution and row shift.
  assign src_idx   = {idx_q[3:2] + idx_q[1:0], idx_q[1:0]};
  assign sub_raddr = s_q[~src_idx];
  assign key_raddr = KeyAw'({rnd_q, col_q});

  arce_ram #(
    .Width(8),
    .Depth(256)
  ) u_sub_ram (
    .clk_i  (clk_i),
    .we_i   (sub_we),
    .waddr_i(table_index_i),
    .wdata_i(table_entry_i),
    .raddr_i(sub_raddr),
    .rdata_o(sub_rdata)
  );

  arce_ram #(
    .Width(32),
    .Depth(KeyWords)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(KeyAw'(key_word_index_i)),
    .wdata_i(key_word_i),
    .raddr_i(key_raddr),
    .rdata_o(key_rdata)
  );

  always_comb begin
    if (round_count_q == 4'd0) begin
      nr_clamped = 4'd1;
    end else if (round_count_q > 4'(MaxRounds)) begin
      nr_clamped = 4'(MaxRounds);
    end else begin
      nr_clamped = round_count_q;
    end
  end

  // Round 0 adds the key straight to the loaded block; the final round skips the mix.
  assign key_src = (rnd_q == 4'd0) ? s_q : t_q;
  assign do_mix  = (rnd_q != 4'd0) && (rnd_q != nr_q);
  assign col_in  = {key_src[~{key_col_q, 2'd0}], key_src[~{key_col_q, 2'd1}],
                    key_src[~{key_col_q, 2'd2}], key_src[~{key_col_q, 2'd3}]};
  assign col_out = (do_mix ? mix_column(col_in) : col_in) ^ key_rdata;

  assign out_load = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  always_comb begin
    t_d = t_q;
    if (sub_vld_q) begin
      t_d[~sub_idx_q] = sub_rdata;
    end
    s_d = s_q;
    if (accept && (opcode_i == OpEncrypt)) begin
      s_d = {plaintext_hi_i, plaintext_lo_i};
    end
    if (key_vld_q) begin
      s_d[~{key_col_q, 2'd0}] = col_out[31:24];
      s_d[~{key_col_q, 2'd1}] = col_out[23:16];
      s_d[~{key_col_q, 2'd2}] = col_out[15:8];
      s_d[~{key_col_q, 2'd3}] = col_out[7:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    nr_d        = nr_q;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    col_d       = col_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept && (opcode_i == OpEncrypt)) begin
          nr_d    = nr_clamped;
          rnd_d   = 4'd0;
          col_d   = 2'd0;
          state_d = StKey;
        end
      end
      StSub: begin
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd15) begin
          col_d   = 2'd0;
          state_d = StKey;
        end
      end
      StKey: begin
        col_d = col_q + 2'd1;
        if (col_q == 2'd3) begin
          state_d = StKeyDrain;
        end
      end
      StKeyDrain: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (rnd_q == nr_q) begin
            state_d = StIdle;
          end else begin
            rnd_d   = rnd_q + 4'd1;
            idx_d   = 4'd0;
            state_d = StSub;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      round_count_q <= 4'd10;
      nr_q          <= 4'd1;
      rnd_q         <= 4'd0;
      idx_q         <= 4'd0;
      col_q         <= 2'd0;
      sub_vld_q     <= 1'b0;
      sub_idx_q     <= 4'd0;
      key_vld_q     <= 1'b0;
      key_col_q     <= 2'd0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        round_count_q <= cfg_wdata_i;
      end
      nr_q        <= nr_d;
      rnd_q       <= rnd_d;
      idx_q       <= idx_d;
      col_q       <= col_d;
      sub_vld_q   <= (state_q == StSub);
      sub_idx_q   <= idx_q;
      key_vld_q   <= (state_q == StKey);
      key_col_q   <= col_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    t_q <= t_d;
    if (out_load) begin
      out_round_q <= rnd_q;
      out_state_q <= s_q;
      out_last_q  <= (rnd_q == nr_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign round_number_o = out_round_q;
  assign state_hi_o     = out_state_q[15:8];
  assign state_lo_o     = out_state_q[7:0];
  assign last_o         = out_last_q;

endmodule

`default_nettype wire

### rtl/arce_ram.sv
`default_nettype none

module arce_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### tb/aes_round_checker.sv
`timescale 1ns / 1ps

module aes_round_checker
  import arce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_entry_i,
  input  logic [5:0]  key_word_index_i,
  input  logic [31:0] key_word_i,
  input  logic [63:0] plaintext_hi_i,
  input  logic [63:0] plaintext_lo_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  round_number_i,
  input  logic [63:0] state_hi_i,
  input  logic [63:0] state_lo_i,
  input  logic        last_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  localparam int unsigned KeyWords = (DefaultMaxRounds + 1) * WordsPerRound;

  typedef struct packed {
    logic [3:0]  rnd;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        fin;
  } round_state_t;

  logic [7:0]   sbox_mem [256];
  logic [31:0]  key_mem [KeyWords];
  logic [3:0]   rounds_cfg;
  round_state_t expected_rounds [$];

  function automatic logic [7:0] times2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(logic [31:0] col);
    logic [7:0]  a [4];
    logic [31:0] res;
    int unsigned r;
    for (r = 0; r < 4; r++) begin
      a[r] = col[31 - 8 * r -: 8];
    end
    for (r = 0; r < 4; r++) begin
      res[31 - 8 * r -: 8] = times2(a[r]) ^ times2(a[(r + 1) % 4]) ^ a[(r + 1) % 4]
                             ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
    end
    return res;
  endfunction

  function automatic logic [127:0] key_add(logic [127:0] st, int unsigned rnd);
    int unsigned c;
    for (c = 0; c < 4; c++) begin
      st[127 - 32 * c -: 32] = st[127 - 32 * c -: 32] ^ key_mem[rnd * 4 + c];
    end
    return st;
  endfunction

  function automatic logic [127:0] sub_shift(logic [127:0] st);
    logic [127:0] res;
    int unsigned  c, r;
    for (c = 0; c < 4; c++) begin
      for (r = 0; r < 4; r++) begin
        res[127 - 8 * (4 * c + r) -: 8] = sbox_mem[st[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
      end
    end
    return res;
  endfunction

  task automatic predict_rounds(input logic [63:0] hi, input logic [63:0] lo);
    logic [127:0] st;
    int unsigned  nr, rnd, c;
    nr = (rounds_cfg == 0) ? 1 : ((rounds_cfg > DefaultMaxRounds) ? DefaultMaxRounds
                                                                   : rounds_cfg);
    st = key_add({hi, lo}, 0);
    expected_rounds.push_back('{4'd0, st[127:64], st[63:0], 1'b0});
    for (rnd = 1; rnd <= nr; rnd++) begin
      st = sub_shift(st);
      if (rnd < nr) begin
        for (c = 0; c < 4; c++) begin
          st[127 - 32 * c -: 32] = mix_col(st[127 - 32 * c -: 32]);
        end
      end
      st = key_add(st, rnd);
      expected_rounds.push_back('{4'(rnd), st[127:64], st[63:0], rnd == nr});
    end
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", field, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i) begin
    round_state_t want;
    if (!rst_ni) begin
      rounds_cfg = 4'd10;
      expected_rounds.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        rounds_cfg = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_rounds.size() == 0) begin
          $error("unexpected result for round %0d", round_number_i);
          errors_o++;
        end else begin
          want = expected_rounds.pop_front();
          compare_field("round_number", 64'(want.rnd), 64'(round_number_i));
          compare_field("state_hi", want.hi, state_hi_i);
          compare_field("state_lo", want.lo, state_lo_i);
          compare_field("last", 64'(want.fin), 64'(last_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (opcode_i)
          OpLoadSub: begin
            sbox_mem[table_index_i] = table_entry_i;
          end
          OpLoadKey: begin
            if (key_word_index_i < KeyWords) begin
              key_mem[key_word_index_i] = key_word_i;
            end
          end
          OpEncrypt: begin
            predict_rounds(plaintext_hi_i, plaintext_lo_i);
          end
          default: begin
          end
        endcase
      end
    end
    pending_o = expected_rounds.size();
  end

endmodule

### tb/tb_aes_round_capture_engine.sv
`timescale 1ns / 1ps

module tb_aes_round_capture_engine;
  import arce_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = '0;
  logic [7:0]  table_index_i = '0;
  logic [7:0]  table_entry_i = '0;
  logic [5:0]  key_word_index_i = '0;
  logic [31:0] key_word_i = '0;
  logic [63:0] plaintext_hi_i = '0;
  logic [63:0] plaintext_lo_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  round_number_o;
  logic [63:0] state_hi_o;
  logic [63:0] state_lo_o;
  logic        last_o;

  int unsigned errors;
  int unsigned pending;
  logic        calm = 1'b0;
  logic        hold_req = 1'b0;

  aes_round_capture_engine DUT (.*);

  aes_round_checker u_round_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .opcode_i         (opcode_i),
    .table_index_i    (table_index_i),
    .table_entry_i    (table_entry_i),
    .key_word_index_i (key_word_index_i),
    .key_word_i       (key_word_i),
    .plaintext_hi_i   (plaintext_hi_i),
    .plaintext_lo_i   (plaintext_lo_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .round_number_i   (round_number_o),
    .state_hi_i       (state_hi_o),
    .state_lo_i       (state_lo_o),
    .last_i           (last_o),
    .errors_o         (errors),
    .pending_o        (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_aes_round_capture_engine: errors");
    $finish;
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  function automatic logic [63:0] random_block();
    return {$urandom, $urandom};
  endfunction

  task automatic offer(input logic [1:0] op, input logic [7:0] tidx, input logic [7:0] tent,
                       input logic [5:0] kidx, input logic [31:0] kword,
                       input logic [63:0] hi, input logic [63:0] lo);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(12, 1)) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    table_index_i    <= tidx;
    table_entry_i    <= tent;
    key_word_index_i <= kidx;
    key_word_i       <= kword;
    plaintext_hi_i   <= hi;
    plaintext_lo_i   <= lo;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [1:0]  op;
    pick = $urandom_range(99);
    if (pick < 55) begin
      op = OpEncrypt;
    end else if (pick < 75) begin
      op = OpLoadSub;
    end else if (pick < 94) begin
      op = OpLoadKey;
    end else begin
      op = OpUnused;
    end
    offer(op, 8'($urandom), 8'($urandom), 6'($urandom), $urandom, random_block(),
          random_block());
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  initial begin
    int unsigned i, p;
    logic [3:0]  plan [6];
    plan = '{4'd0, 4'd1, 4'd14, 4'd15, 4'd5, 4'($urandom_range(15))};

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < 256; i++) begin
      offer(OpLoadSub, 8'(i), 8'($urandom), 6'($urandom), $urandom, random_block(),
            random_block());
    end
    for (i = 0; i < 60; i++) begin
      offer(OpLoadKey, 8'($urandom), 8'($urandom), 6'(i), $urandom, random_block(),
            random_block());
    end

    offer(OpLoadSub, 8'hff, 8'hff, '0, '0, '0, '0);
    offer(OpLoadSub, 8'h00, 8'h00, '1, '1, '1, '1);
    offer(OpLoadKey, '0, '0, 6'd0, 32'h0000_0000, '0, '0);
    offer(OpLoadKey, '1, '1, 6'd59, 32'hffff_ffff, '1, '1);
    offer(OpLoadKey, '0, '0, 6'd60, $urandom, '0, '0);
    offer(OpLoadKey, '1, '1, 6'd63, $urandom, '1, '1);
    offer(OpUnused, 8'h5a, 8'ha5, 6'd7, $urandom, random_block(), random_block());
    offer(OpEncrypt, '0, '0, '0, '0, 64'h0, 64'h0);
    offer(OpEncrypt, '1, '1, '1, '1, '1, '1);
    offer(OpEncrypt, '0, '0, '0, '0, 64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
    offer(OpEncrypt, '0, '0, '0, '0, '1, '0);
    offer(OpEncrypt, '0, '0, '0, '0, '0, '1);
    repeat (15) random_item();

    for (p = 0; p < 6; p++) begin
      settle();
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= plan[p];
      @(negedge clk_i);
      cfg_we_i    <= 1'b0;
      hold_req = (p == 1);
      calm = (p == 4);
      repeat (16) random_item();
    end

    calm = 1'b0;
    settle();
    if (errors == 0) begin
      $display("tb_aes_round_capture_engine: clean");
    end else begin
      $display("tb_aes_round_capture_engine: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/arce_pkg.sv
rtl/arce_ram.sv
rtl/aes_round_capture_engine.sv
tb/aes_round_checker.sv
tb/tb_aes_round_capture_engine.sv
